### rtl/pfsr_pkg.sv
// ----------------------------------------------------------------------------
// pfsr_pkg
// Shared types, widths and codes of the packet field sequence rewriter.
// ----------------------------------------------------------------------------
package pfsr_pkg;

  localparam int MAX_FIELDS   = 16;
  localparam int PACKET_BYTES = 2048;

  localparam int CNT_W = $clog2(MAX_FIELDS + 1);
  localparam int IDX_W = (MAX_FIELDS > 1) ? $clog2(MAX_FIELDS) : 1;
  localparam int POS_W = $clog2(PACKET_BYTES + 1);
  localparam int OFF_W = $clog2(PACKET_BYTES);

  localparam int IN_TDATA_W  = 88;
  localparam int OUT_TDATA_W = 16;

  localparam logic [1:0] CMD_ADD    = 2'd0;
  localparam logic [1:0] CMD_CLEAR  = 2'd1;
  localparam logic [1:0] CMD_DATA   = 2'd2;
  localparam logic [1:0] CMD_UNUSED = 2'd3;

  localparam logic [2:0] ST_OK     = 3'd0;
  localparam logic [2:0] ST_FULL   = 3'd1;
  localparam logic [2:0] ST_SIZE   = 3'd2;
  localparam logic [2:0] ST_OFFSET = 3'd3;
  localparam logic [2:0] ST_MINMAX = 3'd4;

  localparam logic KIND_STATUS = 1'b0;
  localparam logic KIND_DATA   = 1'b1;

  typedef struct packed {
    logic [1:0]  cmd;
    logic [11:0] field_offset;
    logic [2:0]  field_size;
    logic [31:0] field_min;
    logic [31:0] field_max;
    logic [7:0]  data_byte;
    logic        last_byte;
  } item_t;

  typedef struct packed {
    logic       result_kind;
    logic [2:0] status;
    logic [7:0] out_byte;
    logic       out_last;
  } result_t;

endpackage

### rtl/pfsr_table.sv
// ----------------------------------------------------------------------------
// pfsr_table
// Field table with add and clear handling, byte rewrite and counter advance.
// ----------------------------------------------------------------------------
module pfsr_table import pfsr_pkg::*; (
  input  logic    clk_i,
  input  logic    rst_ni,
  input  logic    fire_i,
  input  item_t   item_i,
  output result_t result_o
);

  logic [OFF_W-1:0] entry_offset_q  [MAX_FIELDS];
  logic [2:0]       entry_size_q    [MAX_FIELDS];
  logic [31:0]      entry_min_q     [MAX_FIELDS];
  logic [31:0]      entry_range_q   [MAX_FIELDS];
  logic [31:0]      entry_counter_q [MAX_FIELDS];
  logic [CNT_W-1:0] entry_count_q, entry_count_d;
  logic [POS_W-1:0] byte_position_q, byte_position_d;

  logic        size_ok;
  logic [31:0] cap, lo_c, hi_c, range_raw, range_w;
  logic [12:0] off_end;
  logic [2:0]  add_status;
  logic        do_add, do_clear, do_data, do_advance;

  logic [MAX_FIELDS-1:0] hit;
  logic [POS_W-1:0]      diff [MAX_FIELDS];
  logic                  any_hit;
  logic [1:0]            sel_diff;
  logic [2:0]            sel_size;
  logic [31:0]           sel_min, sel_counter, value;
  logic [1:0]            byte_idx;
  logic [7:0]            new_byte;

  always_comb begin
    size_ok = 1'b1;
    cap     = 32'hffff_ffff;
    case (item_i.field_size)
      3'd1:    cap = 32'h0000_00ff;
      3'd2:    cap = 32'h0000_ffff;
      3'd4:    cap = 32'hffff_ffff;
      default: size_ok = 1'b0;
    endcase
    lo_c      = (item_i.field_min > cap) ? cap : item_i.field_min;
    hi_c      = (item_i.field_max > cap) ? cap : item_i.field_max;
    off_end   = {1'b0, item_i.field_offset} + {10'd0, item_i.field_size};
    range_raw = hi_c - lo_c + 32'd1;
    range_w   = (range_raw == 32'd0) ? 32'hffff_ffff : range_raw;

    if (entry_count_q >= CNT_W'(MAX_FIELDS)) begin
      add_status = ST_FULL;
    end else if (!size_ok) begin
      add_status = ST_SIZE;
    end else if (off_end > 13'(PACKET_BYTES)) begin
      add_status = ST_OFFSET;
    end else if (lo_c > hi_c) begin
      add_status = ST_MINMAX;
    end else begin
      add_status = ST_OK;
    end
  end

  assign do_add     = fire_i && (item_i.cmd == CMD_ADD) && (add_status == ST_OK);
  assign do_clear   = fire_i && (item_i.cmd == CMD_CLEAR);
  assign do_data    = fire_i && (item_i.cmd == CMD_DATA);
  assign do_advance = do_data && item_i.last_byte;

  always_comb begin
    any_hit     = 1'b0;
    sel_diff    = 2'd0;
    sel_size    = 3'd0;
    sel_min     = 32'd0;
    sel_counter = 32'd0;
    for (int k = 0; k < MAX_FIELDS; k++) begin
      diff[k] = byte_position_q - POS_W'(entry_offset_q[k]);
      hit[k]  = (CNT_W'(k) < entry_count_q)
             && (byte_position_q >= POS_W'(entry_offset_q[k]))
             && (diff[k] < POS_W'(entry_size_q[k]));
      if (hit[k]) begin
        any_hit     = 1'b1;
        sel_diff    = diff[k][1:0];
        sel_size    = entry_size_q[k];
        sel_min     = entry_min_q[k];
        sel_counter = entry_counter_q[k];
      end
    end
    value    = sel_min + sel_counter;
    byte_idx = sel_size[1:0] - 2'd1 - sel_diff;
    case (byte_idx)
      2'd0:    new_byte = value[7:0];
      2'd1:    new_byte = value[15:8];
      2'd2:    new_byte = value[23:16];
      2'd3:    new_byte = value[31:24];
      default: new_byte = value[7:0];
    endcase
  end

  always_comb begin
    result_o = '0;
    case (item_i.cmd)
      CMD_ADD: begin
        result_o.result_kind = KIND_STATUS;
        result_o.status      = add_status;
      end
      CMD_CLEAR: begin
        result_o.result_kind = KIND_STATUS;
        result_o.status      = ST_OK;
      end
      CMD_DATA: begin
        result_o.result_kind = KIND_DATA;
        result_o.out_byte    = any_hit ? new_byte : item_i.data_byte;
        result_o.out_last    = item_i.last_byte;
      end
      default: result_o = '0;
    endcase
  end

  always_comb begin
    entry_count_d   = entry_count_q;
    byte_position_d = byte_position_q;
    if (do_clear) begin
      entry_count_d = '0;
    end else if (do_add) begin
      entry_count_d = entry_count_q + CNT_W'(1);
    end
    if (do_data) begin
      if (item_i.last_byte) begin
        byte_position_d = '0;
      end else if (byte_position_q < POS_W'(PACKET_BYTES)) begin
        byte_position_d = byte_position_q + POS_W'(1);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      entry_count_q   <= '0;
      byte_position_q <= '0;
    end else begin
      entry_count_q   <= entry_count_d;
      byte_position_q <= byte_position_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_add) begin
      entry_offset_q[entry_count_q[IDX_W-1:0]] <= item_i.field_offset[OFF_W-1:0];
      entry_size_q[entry_count_q[IDX_W-1:0]]   <= item_i.field_size;
      entry_min_q[entry_count_q[IDX_W-1:0]]    <= lo_c;
      entry_range_q[entry_count_q[IDX_W-1:0]]  <= range_w;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int k = 0; k < MAX_FIELDS; k++) begin
        entry_counter_q[k] <= '0;
      end
    end else begin
      for (int k = 0; k < MAX_FIELDS; k++) begin
        if (do_add && (entry_count_q[IDX_W-1:0] == IDX_W'(k))) begin
          entry_counter_q[k] <= '0;
        end else if (do_advance && (CNT_W'(k) < entry_count_q)) begin
          if ((entry_counter_q[k] + 32'd1) >= entry_range_q[k]) begin
            entry_counter_q[k] <= '0;
          end else begin
            entry_counter_q[k] <= entry_counter_q[k] + 32'd1;
          end
        end
      end
    end
  end

endmodule

### rtl/packet_field_sequence_rewriter.sv
// ----------------------------------------------------------------------------
// packet_field_sequence_rewriter
// Rewrites counter fields of streamed packet bytes from a table of fields.
// ----------------------------------------------------------------------------
// The slave channel carries commands: tuser selects add field, clear table or
// packet byte, tdata carries the field description or the byte, and tlast
// marks the final byte of a packet. Every add, clear and data transfer gives
// exactly one transfer on the master channel: tuser tells a command status
// from a rewritten byte, and tlast copies the packet end. A command code of
// three is taken and dropped without a result.
// An item passes an input register and a result register, which offers its
// result to the master channel and holds it until taken. One item is taken
// every cycle while the receiver keeps up; the compare of the byte position
// against all fields in parallel and the one 32-bit add of the winning field
// set the path between the two registers.
// Reset empties the table and sets the byte position to the start of a
// packet. When the receiver stalls, the result register holds its transfer,
// the input register fills, and tready falls until the result is taken.
// ----------------------------------------------------------------------------
module packet_field_sequence_rewriter import pfsr_pkg::*; (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   s_axis_tvalid_i,
  output logic                   s_axis_tready_o,
  // field_offset[11:0], field_size[14:12], field_min[46:15],
  // field_max[78:47], data_byte[86:79], zero pad [87]
  input  logic [IN_TDATA_W-1:0]  s_axis_tdata_i,
  input  logic                   s_axis_tlast_i,  // last_byte
  input  logic [1:0]             s_axis_tuser_i,  // cmd
  output logic                   m_axis_tvalid_o,
  input  logic                   m_axis_tready_i,
  // status[2:0], out_byte[10:3], zero pad [15:11]
  output logic [OUT_TDATA_W-1:0] m_axis_tdata_o,
  output logic                   m_axis_tlast_o,  // out_last
  output logic                   m_axis_tuser_o   // result_kind
);

  logic    in_valid_q, in_valid_d;
  item_t   in_item_q;
  item_t   in_item;
  logic    out_valid_q, out_valid_d;
  result_t out_q;
  result_t result;
  logic    advance, in_take;

  assign advance         = in_valid_q && (!out_valid_q || m_axis_tready_i);
  assign s_axis_tready_o = !in_valid_q || advance;
  assign in_take         = s_axis_tvalid_i && s_axis_tready_o;

  always_comb begin
    in_item.cmd          = s_axis_tuser_i;
    in_item.field_offset = s_axis_tdata_i[11:0];
    in_item.field_size   = s_axis_tdata_i[14:12];
    in_item.field_min    = s_axis_tdata_i[46:15];
    in_item.field_max    = s_axis_tdata_i[78:47];
    in_item.data_byte    = s_axis_tdata_i[86:79];
    in_item.last_byte    = s_axis_tlast_i;
  end

  always_comb begin
    in_valid_d = in_valid_q;
    if (in_take) begin
      in_valid_d = (s_axis_tuser_i != CMD_UNUSED);
    end else if (advance) begin
      in_valid_d = 1'b0;
    end
    out_valid_d = out_valid_q;
    if (advance) begin
      out_valid_d = 1'b1;
    end else if (m_axis_tready_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      in_valid_q  <= in_valid_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_take) begin
      in_item_q <= in_item;
    end
    if (advance) begin
      out_q <= result;
    end
  end

  pfsr_table u_table (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .fire_i   (advance),
    .item_i   (in_item_q),
    .result_o (result)
  );

  assign m_axis_tvalid_o = out_valid_q;
  assign m_axis_tdata_o  = {5'd0, out_q.out_byte, out_q.status};
  assign m_axis_tlast_o  = out_q.out_last;
  assign m_axis_tuser_o  = out_q.result_kind;

endmodule
